>>> src/assert_macros.svh
// assertion helpers for the scanner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/cmts_pkg.sv
// ----------------------------------------------------------------------------
// cmts_pkg
// Shared types and constants of the token scanner.
// ----------------------------------------------------------------------------
package cmts_pkg;

	localparam int IdentMaxLen  = 255;
	localparam int PositionBits = 16;
	localparam int KwCount      = 14;
	localparam int KwMaxLen     = 8;
	localparam int IdentCntBits = 8;
	localparam logic [31:0] MagMax = 32'h7FFF_FFFF;

	typedef logic [PositionBits-1:0] pos_t;

	typedef enum logic [2:0] {
		PK_IDLE  = 3'd0,
		PK_NUM   = 3'd1,
		PK_IDENT = 3'd2,
		PK_OP    = 3'd3,
		PK_MINUS = 3'd4
	} pend_kind_t;

	typedef enum logic [2:0] {
		TC_NUMBER  = 3'd0,
		TC_IDENT   = 3'd1,
		TC_KEYWORD = 3'd2,
		TC_OPER    = 3'd3,
		TC_HASH    = 3'd4,
		TC_FINISH  = 3'd5,
		TC_ILLEGAL = 3'd6
	} tok_class_t;

	localparam logic [4:0] OP_ANDAND = 5'd0;
	localparam logic [4:0] OP_AND    = 5'd1;
	localparam logic [4:0] OP_OROR   = 5'd2;
	localparam logic [4:0] OP_OR     = 5'd3;
	localparam logic [4:0] OP_LPAR   = 5'd4;
	localparam logic [4:0] OP_RPAR   = 5'd5;
	localparam logic [4:0] OP_SEMI   = 5'd6;
	localparam logic [4:0] OP_ADDEQ  = 5'd7;
	localparam logic [4:0] OP_ADD    = 5'd8;
	localparam logic [4:0] OP_SUBEQ  = 5'd9;
	localparam logic [4:0] OP_SUB    = 5'd10;
	localparam logic [4:0] OP_MULEQ  = 5'd11;
	localparam logic [4:0] OP_MUL    = 5'd12;
	localparam logic [4:0] OP_DIVEQ  = 5'd13;
	localparam logic [4:0] OP_DIV    = 5'd14;
	localparam logic [4:0] OP_EQEQ   = 5'd15;
	localparam logic [4:0] OP_ASSIGN = 5'd16;
	localparam logic [4:0] OP_LE     = 5'd17;
	localparam logic [4:0] OP_SHL    = 5'd18;
	localparam logic [4:0] OP_LT     = 5'd19;
	localparam logic [4:0] OP_GE     = 5'd20;
	localparam logic [4:0] OP_SHR    = 5'd21;
	localparam logic [4:0] OP_GT     = 5'd22;
	localparam logic [4:0] OP_LBRACE = 5'd23;
	localparam logic [4:0] OP_RBRACE = 5'd24;
	localparam logic [4:0] OP_NE     = 5'd25;

	// keyword text, first character in the low byte, zero padded
	localparam logic [KwMaxLen*8-1:0] KW_TEXT [KwCount] = '{
		64'h0000000000746e69, // int
		64'h000000656c696877, // while
		64'h0000000000006f64, // do
		64'h0000000065736c65, // else
		64'h0000000000006669, // if
		64'h000000006e656874, // then
		64'h000000666e616373, // scanf
		64'h000066746e697270, // printf
		64'h006564756c636e69, // include
		64'h6d61657274736f69, // iostream
		64'h0000000000726f66, // for
		64'h0000000072616863, // char
		64'h0000676e69727473, // string
		64'h000000006e69616d  // main
	};
	localparam logic [3:0] KW_LEN [KwCount] = '{
		4'd3, 4'd5, 4'd2, 4'd4, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd3, 4'd4, 4'd6, 4'd4
	};

	// byte of keyword k at position i, zero past its end
	function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
		logic [7:0] r;
		r = 8'd0;
		if (i < 4'd8)
			r = KW_TEXT[k][i[2:0]*8 +: 8];
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	// single-character operator of a pending byte, valid flag in bit 5
	function automatic logic [5:0] single_op(input logic [7:0] p);
		logic [5:0] r;
		case (p)
			8'h26: r = {1'b1, OP_AND};
			8'h7c: r = {1'b1, OP_OR};
			8'h2b: r = {1'b1, OP_ADD};
			8'h2d: r = {1'b1, OP_SUB};
			8'h2a: r = {1'b1, OP_MUL};
			8'h2f: r = {1'b1, OP_DIV};
			8'h3d: r = {1'b1, OP_ASSIGN};
			8'h3c: r = {1'b1, OP_LT};
			8'h3e: r = {1'b1, OP_GT};
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	// two-character operator, valid flag in bit 5
	function automatic logic [5:0] pair_op(input logic [7:0] p, input logic [7:0] c);
		logic [5:0] r;
		r = 6'd0;
		if (p == 8'h26 && c == 8'h26) r = {1'b1, OP_ANDAND};
		else if (p == 8'h7c && c == 8'h7c) r = {1'b1, OP_OROR};
		else if (c == 8'h3d) begin
			case (p)
				8'h2b: r = {1'b1, OP_ADDEQ};
				8'h2d: r = {1'b1, OP_SUBEQ};
				8'h2a: r = {1'b1, OP_MULEQ};
				8'h2f: r = {1'b1, OP_DIVEQ};
				8'h3d: r = {1'b1, OP_EQEQ};
				8'h3c: r = {1'b1, OP_LE};
				8'h3e: r = {1'b1, OP_GE};
				8'h21: r = {1'b1, OP_NE};
				default: r = 6'd0;
			endcase
		end
		else if (p == 8'h3c && c == 8'h3c) r = {1'b1, OP_SHL};
		else if (p == 8'h3e && c == 8'h3e) r = {1'b1, OP_SHR};
		return r;
	endfunction

	// one result beat
	typedef struct packed {
		logic [2:0]  cls;
		logic [4:0]  op;
		logic [3:0]  kw;
		logic [31:0] val;
		logic        ovf;
		logic [7:0]  len;
		logic [7:0]  bad;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} tok_t;

endpackage

>>> src/c_minus_token_scanner.sv
// A result beat is registered into the head slot when the byte that completes it is accepted.
// Throughput: one byte per cycle while the receiver takes every beat; a byte that yields two
// tokens stalls the input until its second beat leaves the skid slot, as does a held head beat.
// Reset: arst_n clears the scanner state (line and column one, nothing pending) and
// empties the output registers; an end-of-input byte also returns the state to reset.
// The second beat of a two-token byte waits in the output skid slot.
// ----------------------------------------------------------------------------
// c_minus_token_scanner
// Streaming lexer: one source byte per beat in, up to two token beats out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c_minus_token_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  token_class,
	output logic [4:0]  operator_code,
	output logic [3:0]  keyword_index,
	output logic signed [31:0] number_value,
	output logic        number_overflow,
	output logic [7:0]  ident_length,
	output logic [7:0]  bad_char,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic        last_of_run
);
	import cmts_pkg::*;

	// scanner state
	pend_kind_t         kind_q;
	logic [7:0]         pchar_q;
	logic [31:0]        acc_q;
	logic               neg_q, ovf_q;
	logic [KwCount-1:0] cand_q;
	logic [IdentCntBits-1:0] icnt_q;
	pos_t               line_q, col_q, sline_q, scol_q;

	// output slots: head shown on the ports, second holds the overflow beat
	tok_t head_q, second_q;
	logic head_v_q, second_v_q;

	pend_kind_t         kind_d;
	logic [7:0]         pchar_d;
	logic [31:0]        acc_d;
	logic               neg_d, ovf_d;
	logic [KwCount-1:0] cand_d;
	logic [IdentCntBits-1:0] icnt_d;
	pos_t               line_d, col_d, sline_d, scol_d;
	tok_t               t0, t1;
	logic               v0, v1;
	logic               accept;
	logic [7:0]         c;

	assign c = char_code;
	// accept while the skid slot is empty and the head beat can move
	assign in_ready = !second_v_q && (!head_v_q || out_ready);
	assign accept   = in_valid && in_ready;

	function automatic logic [15:0] clip16(input pos_t p);
		logic [15:0] r;
		if (PositionBits > 16 && p > pos_t'(16'hFFFF)) r = 16'hFFFF;
		else r = 16'(p);
		return r;
	endfunction

	function automatic tok_t mk(input tok_class_t cls, input logic [4:0] op,
			input logic [3:0] kw, input logic [31:0] val, input logic ovf,
			input logic [7:0] len, input logic [7:0] bad, input pos_t l, input pos_t cc);
		tok_t t;
		t.cls = cls; t.op = op; t.kw = kw; t.val = val; t.ovf = ovf;
		t.len = len; t.bad = bad; t.line = clip16(l); t.col = clip16(cc);
		t.last = 1'b0;
		return t;
	endfunction

	// token for the pending item
	function automatic tok_t flush_tok(input pend_kind_t k, input logic [7:0] pc,
			input logic [31:0] acc, input logic neg, input logic ovf,
			input logic [KwCount-1:0] cand, input logic [IdentCntBits-1:0] cnt,
			input pos_t l, input pos_t cc);
		tok_t t;
		logic [5:0] so;
		logic found;
		logic [3:0] fidx;
		logic [7:0] len8;
		found = 1'b0;
		fidx  = 4'd0;
		len8  = 8'(cnt);
		so    = single_op(pc);
		for (int i = 0; i < KwCount; i++)
			if (cand[i] && IdentCntBits'(KW_LEN[i]) == cnt) begin
				found = 1'b1;
				fidx  = 4'(i);
			end
		case (k)
			PK_NUM:   t = mk(TC_NUMBER, 5'd0, 4'd0, neg ? (32'd0 - acc) : acc, ovf,
				8'd0, 8'd0, l, cc);
			PK_IDENT: t = found ? mk(TC_KEYWORD, 5'd0, fidx, 32'd0, 1'b0, len8, 8'd0, l, cc)
				: mk(TC_IDENT, 5'd0, 4'd0, 32'd0, 1'b0, len8, 8'd0, l, cc);
			PK_OP:    t = so[5] ? mk(TC_OPER, so[4:0], 4'd0, 32'd0, 1'b0, 8'd0, 8'd0, l, cc)
				: mk(TC_ILLEGAL, 5'd0, 4'd0, 32'd0, 1'b0, 8'd0, pc, l, cc);
			default:  t = mk(TC_OPER, OP_SUB, 4'd0, 32'd0, 1'b0, 8'd0, 8'd0, l, cc);
		endcase
		return t;
	endfunction

	// next scanner state and up to two token beats
	always_comb begin
		logic consumed;
		logic [5:0] po;
		logic [7:0] pc_eff;
		logic [3:0] d;
		logic [35:0] prod;
		logic [IdentCntBits-1:0] ci;
		logic [KwCount-1:0] cand_base;
		logic [4:0] sop;
		tok_t ft;
		kind_d = kind_q; pchar_d = pchar_q; acc_d = acc_q; neg_d = neg_q; ovf_d = ovf_q;
		cand_d = cand_q; icnt_d = icnt_q; line_d = line_q; col_d = col_q;
		sline_d = sline_q; scol_d = scol_q;
		v0 = 1'b0; v1 = 1'b0;
		t0 = '0; t1 = '0;
		consumed = 1'b0;
		d = c[3:0];
		pc_eff = (kind_q == PK_MINUS) ? 8'h2d : pchar_q;
		po = pair_op(pc_eff, c);
		ft = flush_tok(kind_q, pc_eff, acc_q, neg_q, ovf_q, cand_q, icnt_q, sline_q, scol_q);
		prod = 36'(acc_q) * 36'd10 + 36'(d);
		cand_base = cand_q;
		ci = icnt_q;
		sop = 5'd0;

		if (end_of_input) begin
			if (kind_q != PK_IDLE) begin
				v0 = 1'b1; t0 = ft;
				v1 = 1'b1;
				t1 = mk(TC_FINISH, 5'd0, 4'd0, 32'd0, 1'b0, 8'd0, 8'd0, line_q, col_q);
			end else begin
				v0 = 1'b1;
				t0 = mk(TC_FINISH, 5'd0, 4'd0, 32'd0, 1'b0, 8'd0, 8'd0, line_q, col_q);
			end
			kind_d = PK_IDLE; pchar_d = 8'd0; acc_d = 32'd0; neg_d = 1'b0; ovf_d = 1'b0;
			cand_d = '1; icnt_d = '0;
			line_d = pos_t'(1); col_d = pos_t'(1); sline_d = pos_t'(1); scol_d = pos_t'(1);
		end else begin
			case (kind_q)
				PK_NUM: begin
					if (is_digit(c)) begin
						consumed = 1'b1;
						if (ovf_q || prod > 36'(MagMax)) begin
							acc_d = MagMax; ovf_d = 1'b1;
						end else acc_d = prod[31:0];
					end else begin
						v0 = 1'b1; t0 = ft; kind_d = PK_IDLE;
					end
				end
				PK_IDENT: begin
					if (is_alpha(c) || is_digit(c)) consumed = 1'b1;
					else begin
						v0 = 1'b1; t0 = ft; kind_d = PK_IDLE;
					end
				end
				PK_MINUS, PK_OP: begin
					if (kind_q == PK_MINUS && is_digit(c)) begin
						consumed = 1'b1;
						kind_d = PK_NUM; acc_d = 32'(d); ovf_d = 1'b0; neg_d = 1'b1;
					end else begin
						pchar_d = pc_eff;
						if (po[5]) begin
							consumed = 1'b1; v0 = 1'b1;
							t0 = mk(TC_OPER, po[4:0], 4'd0, 32'd0, 1'b0, 8'd0, 8'd0,
								sline_q, scol_q);
						end else begin
							v0 = 1'b1; t0 = ft;
						end
						kind_d = PK_IDLE;
					end
				end
				default: ;
			endcase

			// identifier start resets the keyword match
			if (!consumed && is_alpha(c)) begin
				cand_base = '1; ci = '0;
			end
			if ((kind_q == PK_IDENT && consumed) || (!consumed && is_alpha(c))) begin
				for (int k = 0; k < KwCount; k++)
					if (ci >= IdentCntBits'(KW_LEN[k]) || kw_char(k, 4'(ci)) != c)
						cand_base[k] = 1'b0;
				cand_d = cand_base;
				icnt_d = (ci < IdentCntBits'(IdentMaxLen)) ? ci + 1'b1 : ci;
			end

			if (!consumed && !is_space(c)) begin
				if (is_digit(c)) begin
					kind_d = PK_NUM; sline_d = line_q; scol_d = col_q;
					acc_d = 32'(d); neg_d = 1'b0; ovf_d = 1'b0;
				end else if (is_alpha(c)) begin
					kind_d = PK_IDENT; sline_d = line_q; scol_d = col_q;
				end else if (c == 8'h2d) begin
					kind_d = PK_MINUS; sline_d = line_q; scol_d = col_q; pchar_d = 8'h2d;
				end else if (c == 8'h26 || c == 8'h7c || c == 8'h2b || c == 8'h2a ||
						c == 8'h2f || c == 8'h3d || c == 8'h3c || c == 8'h3e ||
						c == 8'h21) begin
					kind_d = PK_OP; sline_d = line_q; scol_d = col_q; pchar_d = c;
				end else begin
					case (c)
						8'h28: sop = OP_LPAR;
						8'h29: sop = OP_RPAR;
						8'h3b: sop = OP_SEMI;
						8'h7b: sop = OP_LBRACE;
						8'h7d: sop = OP_RBRACE;
						default: sop = 5'd0;
					endcase
					if (c == 8'h28 || c == 8'h29 || c == 8'h3b || c == 8'h7b || c == 8'h7d)
						ft = mk(TC_OPER, sop, 4'd0, 32'd0, 1'b0, 8'd0, 8'd0, line_q, col_q);
					else if (c == 8'h23)
						ft = mk(TC_HASH, 5'd0, 4'd0, 32'd0, 1'b0, 8'd0, 8'd0, line_q, col_q);
					else
						ft = mk(TC_ILLEGAL, 5'd0, 4'd0, 32'd0, 1'b0, 8'd0, c, line_q, col_q);
					if (v0) begin
						v1 = 1'b1; t1 = ft;
					end else begin
						v0 = 1'b1; t0 = ft;
					end
				end
			end

			// position update
			if (c == 8'h0a) begin
				if (line_q != '1) line_d = line_q + 1'b1;
				col_d = pos_t'(1);
			end else if (col_q != '1) col_d = col_q + 1'b1;
		end

		if (v1) t1.last = 1'b1;
		else if (v0) t0.last = 1'b1;
	end

	// scanner state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= PK_IDLE; pchar_q <= 8'd0; acc_q <= 32'd0; neg_q <= 1'b0;
			ovf_q <= 1'b0; cand_q <= '1; icnt_q <= '0;
			line_q <= pos_t'(1); col_q <= pos_t'(1);
			sline_q <= pos_t'(1); scol_q <= pos_t'(1);
		end else if (accept) begin
			kind_q <= kind_d; pchar_q <= pchar_d; acc_q <= acc_d; neg_q <= neg_d;
			ovf_q <= ovf_d; cand_q <= cand_d; icnt_q <= icnt_d;
			line_q <= line_d; col_q <= col_d; sline_q <= sline_d; scol_q <= scol_d;
		end
	end

	// output slots: head moves when taken, second refills head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0; second_v_q <= 1'b0;
			head_q <= '0; second_q <= '0;
		end else begin
			if (!head_v_q || out_ready) begin
				if (second_v_q) begin
					head_q <= second_q; head_v_q <= 1'b1; second_v_q <= 1'b0;
				end else if (accept && v0) begin
					head_q <= t0; head_v_q <= 1'b1;
					if (v1) begin
						second_q <= t1; second_v_q <= 1'b1;
					end
				end else head_v_q <= 1'b0;
			end
		end
	end

	assign out_valid       = head_v_q;
	assign token_class     = head_q.cls;
	assign operator_code   = head_q.op;
	assign keyword_index   = head_q.kw;
	assign number_value    = head_q.val;
	assign number_overflow = head_q.ovf;
	assign ident_length    = head_q.len;
	assign bad_char        = head_q.bad;
	assign token_line      = head_q.line;
	assign token_column    = head_q.col;
	assign last_of_run     = head_q.last;

	`ASSERT_IMPL(a_second_needs_head, clk, arst_n, second_v_q, head_v_q,
		"skid beat without head beat")
	`ASSERT_IMPL(a_no_accept_full, clk, arst_n, second_v_q, !in_ready,
		"input taken while skid slot full")
	`ASSERT_NEXT(a_finish_resets, clk, arst_n, accept && end_of_input,
		kind_q == PK_IDLE && line_q == pos_t'(1), "finish did not reset scanner")
	`ASSERT_IMPL(a_ovf_saturates, clk, arst_n, ovf_q && kind_q == PK_NUM, acc_q == MagMax,
		"overflowed number not saturated")

endmodule
